// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned MaxPayloadW = 25;
  localparam logic [63:0] MaxPayloadReset = 64'd16777216;

  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'ha;

  localparam logic [6:0] Len16 = 7'd126;
  localparam logic [6:0] Len64 = 7'd127;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CLOSE     = 3'd1,
    ST_FRAME_LEN = 3'd2,
    ST_DATA_FRAG = 3'd3,
    ST_ORPHAN    = 3'd4,
    ST_MSG_LEN   = 3'd5,
    ST_BAD_OP    = 3'd6
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       ping_payload;
    logic       last;
    status_e    status;
  } wsd_result_t;

endpackage

// ----- hw/rtl/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Bytes pass the input reg, then the result reg. Throughput: one byte per cycle while
// the result side keeps tready high. Pong payload and header bytes give no result item,
// save an error or zero-length end item on a header's last byte; after an error all
// input is dropped. Reset (async, active low) returns to the first header byte, clears
// fragment state and sets the payload limit to 16777216 clipped to the count width.
module websocket_frame_deframer_core #(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [4:0]  m_axis_tuser,   // byte_valid, ping_payload, status[2:0]
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wsd_pkg::MaxPayloadW-1:0] cfg_data_i
);
  import wsd_pkg::*;

  localparam logic [63:0] CountMask  = {64{1'b1}} >> (64 - COUNT_WIDTH);
  localparam logic [63:0] LimitReset =
      (MaxPayloadReset > CountMask) ? CountMask : MaxPayloadReset;

  logic        in_valid_q;
  logic [7:0]  in_data_q;
  logic [63:0] limit_q, limit_d, cfg_ext;
  logic        out_free, step;
  wsd_result_t res;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign cfg_ext = {{(64 - MaxPayloadW){1'b0}}, cfg_data_i};
  assign limit_d = (cfg_ext > CountMask) ? CountMask : cfg_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      limit_q    <= LimitReset;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (cfg_valid_i) limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_data_q <= s_axis_tdata;
  end

  wsd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_data_q),
    .limit_i(limit_q),
    .res_o  (res)
  );

  wsd_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .free_o         (out_free),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

endmodule

// ----- hw/rtl/wsd_parser.sv -----
// Frame header parser, unmasking and fragment tracking, one byte per step.
module wsd_parser #(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [63:0]         limit_i,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   fin_q, fin_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   masked_q, masked_d;
  logic [63:0]            flen_q, flen_d;
  logic [2:0]             hbc_q, hbc_d;
  logic [31:0]            key_q, key_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [1:0]             idx_q, idx_d;
  logic                   asm_q, asm_d;
  logic [COUNT_WIDTH-1:0] msg_q, msg_d;

  logic        finish;
  logic [63:0] fl;
  logic [64:0] sum;
  logic        too_long, msg_over, err, ends, is_ping, final_byte;
  status_e     err_code;
  logic [7:0]  key_byte;

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    flen_d   = flen_q;
    hbc_d    = hbc_q;
    key_d    = key_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    asm_d    = asm_q;
    msg_d    = msg_q;
    finish   = 1'b0;
    fl       = flen_q;
    err      = 1'b0;
    err_code = ST_OK;
    ends     = 1'b0;
    is_ping  = 1'b0;
    res_o    = '0;

    final_byte = (rem_q == COUNT_WIDTH'(1));
    unique case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!masked_q) key_byte = 8'h00;

    if (step_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d    = byte_i[7];
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = byte_i[7];
          flen_d   = '0;
          if (byte_i[6:0] == Len16) begin
            hbc_d   = 3'd1;
            phase_d = PH_EXT;
          end else if (byte_i[6:0] == Len64) begin
            hbc_d   = 3'd7;
            phase_d = PH_EXT;
          end else begin
            flen_d = {57'd0, byte_i[6:0]};
            fl     = flen_d;
            if (byte_i[7]) begin
              hbc_d   = 3'd3;
              phase_d = PH_MASK;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_EXT: begin
          flen_d = {flen_q[55:0], byte_i};
          fl     = flen_d;
          if (hbc_q == 3'd0) begin
            if (masked_q) begin
              hbc_d   = 3'd3;
              phase_d = PH_MASK;
            end else begin
              finish = 1'b1;
            end
          end else begin
            hbc_d = hbc_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          if (hbc_q == 3'd0) finish = 1'b1;
          else hbc_d = hbc_q - 3'd1;
        end
        PH_PAYLOAD: begin
          if (opcode_q == OpPing) begin
            res_o.valid        = 1'b1;
            res_o.out_byte     = byte_i ^ key_byte;
            res_o.byte_valid   = 1'b1;
            res_o.ping_payload = 1'b1;
            res_o.last         = final_byte;
          end else if (opcode_q != OpPong) begin
            res_o.valid      = 1'b1;
            res_o.out_byte   = byte_i ^ key_byte;
            res_o.byte_valid = 1'b1;
            res_o.last       = final_byte & fin_q;
          end
          rem_d = rem_q - COUNT_WIDTH'(1);
          idx_d = idx_q + 2'd1;
          if (final_byte) phase_d = PH_HDR0;
        end
        PH_HALT: begin
        end
        default: begin
        end
      endcase
    end

    sum      = {1'b0, 64'(msg_q)} + {1'b0, fl};
    too_long = fl > limit_i;
    msg_over = sum > {1'b0, limit_i};

    if (finish) begin
      if (too_long) begin
        err      = 1'b1;
        err_code = ST_FRAME_LEN;
      end else begin
        priority case (opcode_q)
          OpClose: begin
            err      = 1'b1;
            err_code = ST_CLOSE;
          end
          OpPing: begin
            ends    = 1'b1;
            is_ping = 1'b1;
          end
          OpPong: ends = 1'b0;
          OpText, OpBin: begin
            if (asm_q) begin
              err      = 1'b1;
              err_code = ST_DATA_FRAG;
            end else begin
              if (!fin_q) begin
                asm_d = 1'b1;
                msg_d = fl[COUNT_WIDTH-1:0];
              end
              ends = fin_q;
            end
          end
          OpCont: begin
            if (!asm_q) begin
              err      = 1'b1;
              err_code = ST_ORPHAN;
            end else if (msg_over) begin
              err      = 1'b1;
              err_code = ST_MSG_LEN;
            end else begin
              msg_d = sum[COUNT_WIDTH-1:0];
              if (fin_q) begin
                asm_d = 1'b0;
                msg_d = '0;
              end
              ends = fin_q;
            end
          end
          default: begin
            err      = 1'b1;
            err_code = ST_BAD_OP;
          end
        endcase
      end

      if (err) begin
        phase_d      = PH_HALT;
        asm_d        = asm_q;
        msg_d        = msg_q;
        res_o        = '0;
        res_o.valid  = 1'b1;
        res_o.status = err_code;
      end else begin
        rem_d = fl[COUNT_WIDTH-1:0];
        idx_d = 2'd0;
        if (fl == 64'd0) begin
          phase_d = PH_HDR0;
          if (ends) begin
            res_o.valid        = 1'b1;
            res_o.ping_payload = is_ping;
            res_o.last         = 1'b1;
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      opcode_q <= 4'd0;
      masked_q <= 1'b0;
      hbc_q    <= 3'd0;
      rem_q    <= '0;
      idx_q    <= 2'd0;
      asm_q    <= 1'b0;
      msg_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      hbc_q    <= hbc_d;
      rem_q    <= rem_d;
      idx_q    <= idx_d;
      asm_q    <= asm_d;
      msg_q    <= msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q <= flen_d;
    key_q  <= key_d;
  end

endmodule

// ----- hw/rtl/wsd_out_stage.sv -----
// Result register on the master side of the stream.
module wsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsd_pkg::wsd_result_t res_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,  // out_byte
  output logic [4:0]           m_axis_tuser_o,  // byte_valid, ping_payload, status[2:0]
  output logic                 m_axis_tlast_o   // last
);
  import wsd_pkg::*;

  logic        valid_q;
  wsd_result_t res_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) res_q <= res_i;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.out_byte;
  assign m_axis_tuser_o  = {res_q.status, res_q.ping_payload, res_q.byte_valid};
  assign m_axis_tlast_o  = res_q.last;

endmodule
